[rtl/rv32im_dec_pkg.sv]
// ----------------------------------------------------------------------------
// rv32im_dec_pkg
// Shared opcodes, operation numbers, format codes and the machine CSR map
// used by the RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rv32im_dec_pkg;

   // Base opcodes (inst[6:0])
   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
   localparam logic [6:0] OPC_TRAP   = 7'b1101011;

   // funct7 codes
   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_MULDIV = 7'b0000001;
   localparam logic [6:0] F7_ALT = 7'b0100000;

   // Whole words matched before the opcode decode
   localparam logic [31:0] WORD_ECALL = 32'h0000_0073;
   localparam logic [31:0] WORD_MRET  = 32'h3020_0073;
   localparam logic [31:0] WORD_FENCE = 32'h0FF0_000F;

   // Compressed C.JAL: quadrant 1, funct3 001
   localparam logic [1:0] CQ_QUAD1 = 2'b01;
   localparam logic [2:0] CF3_JAL  = 3'b001;

   // Instruction formats
   localparam logic [2:0] FMT_R = 3'd0;
   localparam logic [2:0] FMT_I = 3'd1;
   localparam logic [2:0] FMT_S = 3'd2;
   localparam logic [2:0] FMT_B = 3'd3;
   localparam logic [2:0] FMT_U = 3'd4;
   localparam logic [2:0] FMT_J = 3'd5;

   // Operation numbers
   localparam logic [5:0] OP_ADD    = 6'd0;
   localparam logic [5:0] OP_SUB    = 6'd1;
   localparam logic [5:0] OP_XOR    = 6'd2;
   localparam logic [5:0] OP_OR     = 6'd3;
   localparam logic [5:0] OP_AND    = 6'd4;
   localparam logic [5:0] OP_SLL    = 6'd5;
   localparam logic [5:0] OP_SRL    = 6'd6;
   localparam logic [5:0] OP_SRA    = 6'd7;
   localparam logic [5:0] OP_SLT    = 6'd8;
   localparam logic [5:0] OP_SLTU   = 6'd9;
   localparam logic [5:0] OP_MUL    = 6'd10;   // mul..remu follow funct3
   localparam logic [5:0] OP_LUI    = 6'd18;
   localparam logic [5:0] OP_LB     = 6'd19;
   localparam logic [5:0] OP_LH     = 6'd20;
   localparam logic [5:0] OP_LW     = 6'd21;
   localparam logic [5:0] OP_LBU    = 6'd22;
   localparam logic [5:0] OP_LHU    = 6'd23;
   localparam logic [5:0] OP_SB     = 6'd24;
   localparam logic [5:0] OP_SH     = 6'd25;
   localparam logic [5:0] OP_SW     = 6'd26;
   localparam logic [5:0] OP_ADDI   = 6'd27;
   localparam logic [5:0] OP_XORI   = 6'd28;
   localparam logic [5:0] OP_ORI    = 6'd29;
   localparam logic [5:0] OP_ANDI   = 6'd30;
   localparam logic [5:0] OP_SLLI   = 6'd31;
   localparam logic [5:0] OP_SRLI   = 6'd32;
   localparam logic [5:0] OP_SRAI   = 6'd33;
   localparam logic [5:0] OP_SLTI   = 6'd34;
   localparam logic [5:0] OP_SET_LT_IMM_U = 6'd35;
   localparam logic [5:0] OP_BEQ    = 6'd36;
   localparam logic [5:0] OP_BNE    = 6'd37;
   localparam logic [5:0] OP_BLT    = 6'd38;
   localparam logic [5:0] OP_BGE    = 6'd39;
   localparam logic [5:0] OP_BLTU   = 6'd40;
   localparam logic [5:0] OP_BGEU   = 6'd41;
   localparam logic [5:0] OP_JALR   = 6'd42;
   localparam logic [5:0] OP_PC_UPPER = 6'd43;
   localparam logic [5:0] OP_JAL    = 6'd44;
   localparam logic [5:0] OP_CSR_SWAP    = 6'd45;
   localparam logic [5:0] OP_CSR_SETBITS = 6'd46;
   localparam logic [5:0] OP_CSR_CLRBITS = 6'd47;
   localparam logic [5:0] OP_TRAP   = 6'd48;
   localparam logic [5:0] OP_ENV_CALL  = 6'd49;
   localparam logic [5:0] OP_MRET   = 6'd50;
   localparam logic [5:0] OP_MEM_ORDER = 6'd51;
   localparam logic [5:0] OP_CJAL   = 6'd52;

   // CSR map
   localparam logic [3:0] CSR_MSTATUS  = 4'd0;
   localparam logic [3:0] CSR_MISA     = 4'd1;
   localparam logic [3:0] CSR_MIE      = 4'd2;
   localparam logic [3:0] CSR_MTVEC    = 4'd3;
   localparam logic [3:0] CSR_MSCRATCH = 4'd4;
   localparam logic [3:0] CSR_MEPC     = 4'd5;
   localparam logic [3:0] CSR_MCAUSE   = 4'd6;
   localparam logic [3:0] CSR_MTVAL    = 4'd7;
   localparam logic [3:0] CSR_MIP      = 4'd8;
   localparam logic [3:0] CSR_NONE     = 4'd9;

   localparam logic [4:0] REG_RA = 5'd1;

   // Kind of word seen by the classify stage
   typedef enum logic [1:0] {
      KIND_DECODED = 2'd0,
      KIND_CJAL    = 2'd1,
      KIND_SYSWORD = 2'd2,
      KIND_ILLEGAL = 2'd3
   } kind_type;

   typedef struct packed {
      logic [5:0] op;
      logic [2:0] fmt;
      logic [3:0] csr;
      kind_type   kind;
   } decode_type;

   function automatic logic [3:0] csr_lookup(input logic [11:0] addr);
      logic [3:0] idx;
      case (addr)
         12'h300: idx = CSR_MSTATUS;
         12'h301: idx = CSR_MISA;
         12'h304: idx = CSR_MIE;
         12'h305: idx = CSR_MTVEC;
         12'h340: idx = CSR_MSCRATCH;
         12'h341: idx = CSR_MEPC;
         12'h342: idx = CSR_MCAUSE;
         12'h343: idx = CSR_MTVAL;
         12'h344: idx = CSR_MIP;
         default: idx = CSR_NONE;
      endcase
      return idx;
   endfunction

   // funct3 -> op for funct7 = 0 register ops
   function automatic logic [5:0] alu_op(input logic [2:0] f3);
      logic [5:0] op;
      case (f3)
         3'd0:    op = OP_ADD;
         3'd1:    op = OP_SLL;
         3'd2:    op = OP_SLT;
         3'd3:    op = OP_SLTU;
         3'd4:    op = OP_XOR;
         3'd5:    op = OP_SRL;
         3'd6:    op = OP_OR;
         default: op = OP_AND;
      endcase
      return op;
   endfunction

endpackage

[rtl/rv32im_instruction_decoder_top.sv]
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_top
// Pipelined RV32IM decoder with CSR map, custom trap opcode and C.JAL.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+-------------------------------
//   req     | in  | req_valid / req_stall      | req_instruction
//   rsp     | out | rsp_valid / rsp_stall      | op, format, regs, imm, csr, flags
//
// Three register stages: capture, classify (opcode/funct/CSR match), field
// assembly (registers, immediate). rsp_valid is the valid bit of the third
// stage; one instruction per cycle is sustained while rsp_stall is low.
// Synchronous active-high reset clears the stage valid bits only.
// A stall on rsp holds each stage whose successor is full; empty stages keep
// filling, so req_stall rises only when all three stages hold an item and
// rsp_stall is high.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_top (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_instruction,
   // response
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_op_index,
   output logic [2:0]         rsp_format_kind,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic [4:0]         rsp_dest_reg,
   output logic               rsp_dest_write,
   output logic signed [31:0] rsp_immediate,
   output logic [3:0]         rsp_csr_index,
   output logic               rsp_is_compressed,
   output logic               rsp_illegal
);

   // stage advance enables, computed back from the output
   logic s3_adv, s2_adv, s1_adv;

   // stage 1: capture
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_word_ff;

   // stage 2: classify
   logic                     s2_valid_ff, s2_valid_in;
   logic [31:0]              s2_word_ff;
   rv32im_dec_pkg::decode_type s2_dec_ff, s2_dec_in;

   // stage 3: output register
   logic                     s3_valid_ff, s3_valid_in;
   logic [5:0]               op_ff, op_in;
   logic [2:0]               fmt_ff, fmt_in;
   logic [4:0]               src1_ff, src1_in;
   logic [4:0]               src2_ff, src2_in;
   logic [4:0]               dest_ff, dest_in;
   logic                     we_ff, we_in;
   logic [31:0]              imm_ff, imm_in;
   logic [3:0]               csr_ff, csr_in;
   logic                     comp_ff, comp_in;
   logic                     ill_ff, ill_in;

   // classify helpers
   logic       dec_ok;
   logic [6:0] w_opc;
   logic [2:0] w_f3;
   logic [6:0] w_f7;

   assign s3_adv = !s3_valid_ff || !rsp_stall;
   assign s2_adv = !s2_valid_ff || s3_adv;
   assign s1_adv = !s1_valid_ff || s2_adv;

   assign req_stall = !s1_adv;

   assign s1_valid_in = s1_adv ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // ---- stage 1 ----
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_word_ff <= req_instruction;
      end
   end

   // ---- stage 2: classify ----
   assign w_opc = s1_word_ff[6:0];
   assign w_f3  = s1_word_ff[14:12];
   assign w_f7  = s1_word_ff[31:25];

   always_comb begin
      s2_dec_in.op   = rv32im_dec_pkg::OP_ADD;
      s2_dec_in.fmt  = rv32im_dec_pkg::FMT_R;
      s2_dec_in.csr  = rv32im_dec_pkg::CSR_NONE;
      s2_dec_in.kind = rv32im_dec_pkg::KIND_DECODED;
      dec_ok         = 1'b1;
      if (s1_word_ff[1:0] == rv32im_dec_pkg::CQ_QUAD1 &&
          s1_word_ff[15:13] == rv32im_dec_pkg::CF3_JAL) begin
         s2_dec_in.op   = rv32im_dec_pkg::OP_CJAL;
         s2_dec_in.fmt  = rv32im_dec_pkg::FMT_J;
         s2_dec_in.kind = rv32im_dec_pkg::KIND_CJAL;
      end else if (s1_word_ff == rv32im_dec_pkg::WORD_ECALL) begin
         s2_dec_in.op   = rv32im_dec_pkg::OP_ENV_CALL;
         s2_dec_in.fmt  = rv32im_dec_pkg::FMT_I;
         s2_dec_in.kind = rv32im_dec_pkg::KIND_SYSWORD;
      end else if (s1_word_ff == rv32im_dec_pkg::WORD_MRET) begin
         s2_dec_in.op   = rv32im_dec_pkg::OP_MRET;
         s2_dec_in.fmt  = rv32im_dec_pkg::FMT_I;
         s2_dec_in.kind = rv32im_dec_pkg::KIND_SYSWORD;
      end else if (s1_word_ff == rv32im_dec_pkg::WORD_FENCE) begin
         s2_dec_in.op   = rv32im_dec_pkg::OP_MEM_ORDER;
         s2_dec_in.fmt  = rv32im_dec_pkg::FMT_I;
         s2_dec_in.kind = rv32im_dec_pkg::KIND_SYSWORD;
      end else begin
         case (w_opc)
            rv32im_dec_pkg::OPC_OP: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_R;
               if (w_f7 == rv32im_dec_pkg::F7_BASE) begin
                  s2_dec_in.op = rv32im_dec_pkg::alu_op(w_f3);
               end else if (w_f7 == rv32im_dec_pkg::F7_MULDIV) begin
                  s2_dec_in.op = rv32im_dec_pkg::OP_MUL + {3'b000, w_f3};
               end else if (w_f7 == rv32im_dec_pkg::F7_ALT && w_f3 == 3'd0) begin
                  s2_dec_in.op = rv32im_dec_pkg::OP_SUB;
               end else if (w_f7 == rv32im_dec_pkg::F7_ALT && w_f3 == 3'd5) begin
                  s2_dec_in.op = rv32im_dec_pkg::OP_SRA;
               end else begin
                  dec_ok = 1'b0;
               end
            end
            rv32im_dec_pkg::OPC_LUI: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_U;
               s2_dec_in.op  = rv32im_dec_pkg::OP_LUI;
            end
            rv32im_dec_pkg::OPC_LOAD: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_I;
               case (w_f3)
                  3'd0:    s2_dec_in.op = rv32im_dec_pkg::OP_LB;
                  3'd1:    s2_dec_in.op = rv32im_dec_pkg::OP_LH;
                  3'd2:    s2_dec_in.op = rv32im_dec_pkg::OP_LW;
                  3'd4:    s2_dec_in.op = rv32im_dec_pkg::OP_LBU;
                  3'd5:    s2_dec_in.op = rv32im_dec_pkg::OP_LHU;
                  default: dec_ok = 1'b0;
               endcase
            end
            rv32im_dec_pkg::OPC_STORE: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_S;
               case (w_f3)
                  3'd0:    s2_dec_in.op = rv32im_dec_pkg::OP_SB;
                  3'd1:    s2_dec_in.op = rv32im_dec_pkg::OP_SH;
                  3'd2:    s2_dec_in.op = rv32im_dec_pkg::OP_SW;
                  default: dec_ok = 1'b0;
               endcase
            end
            rv32im_dec_pkg::OPC_OPIMM: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_I;
               case (w_f3)
                  3'd0: s2_dec_in.op = rv32im_dec_pkg::OP_ADDI;
                  3'd4: s2_dec_in.op = rv32im_dec_pkg::OP_XORI;
                  3'd6: s2_dec_in.op = rv32im_dec_pkg::OP_ORI;
                  3'd7: s2_dec_in.op = rv32im_dec_pkg::OP_ANDI;
                  3'd2: s2_dec_in.op = rv32im_dec_pkg::OP_SLTI;
                  3'd3: s2_dec_in.op = rv32im_dec_pkg::OP_SET_LT_IMM_U;
                  3'd1: begin
                     if (w_f7 == rv32im_dec_pkg::F7_BASE) begin
                        s2_dec_in.op = rv32im_dec_pkg::OP_SLLI;
                     end else begin
                        dec_ok = 1'b0;
                     end
                  end
                  default: begin
                     if (w_f7 == rv32im_dec_pkg::F7_BASE) begin
                        s2_dec_in.op = rv32im_dec_pkg::OP_SRLI;
                     end else if (w_f7 == rv32im_dec_pkg::F7_ALT) begin
                        s2_dec_in.op = rv32im_dec_pkg::OP_SRAI;
                     end else begin
                        dec_ok = 1'b0;
                     end
                  end
               endcase
            end
            rv32im_dec_pkg::OPC_BRANCH: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_B;
               case (w_f3)
                  3'd0:    s2_dec_in.op = rv32im_dec_pkg::OP_BEQ;
                  3'd1:    s2_dec_in.op = rv32im_dec_pkg::OP_BNE;
                  3'd4:    s2_dec_in.op = rv32im_dec_pkg::OP_BLT;
                  3'd5:    s2_dec_in.op = rv32im_dec_pkg::OP_BGE;
                  3'd6:    s2_dec_in.op = rv32im_dec_pkg::OP_BLTU;
                  3'd7:    s2_dec_in.op = rv32im_dec_pkg::OP_BGEU;
                  default: dec_ok = 1'b0;
               endcase
            end
            rv32im_dec_pkg::OPC_JALR: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_I;
               if (w_f3 == 3'd0) begin
                  s2_dec_in.op = rv32im_dec_pkg::OP_JALR;
               end else begin
                  dec_ok = 1'b0;
               end
            end
            rv32im_dec_pkg::OPC_AUIPC: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_U;
               s2_dec_in.op  = rv32im_dec_pkg::OP_PC_UPPER;
            end
            rv32im_dec_pkg::OPC_JAL: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_J;
               s2_dec_in.op  = rv32im_dec_pkg::OP_JAL;
            end
            rv32im_dec_pkg::OPC_SYSTEM: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_I;
               s2_dec_in.csr = rv32im_dec_pkg::csr_lookup(s1_word_ff[31:20]);
               if (s2_dec_in.csr == rv32im_dec_pkg::CSR_NONE) begin
                  dec_ok = 1'b0;
               end else begin
                  case (w_f3)
                     3'd1:    s2_dec_in.op = rv32im_dec_pkg::OP_CSR_SWAP;
                     3'd2:    s2_dec_in.op = rv32im_dec_pkg::OP_CSR_SETBITS;
                     3'd3:    s2_dec_in.op = rv32im_dec_pkg::OP_CSR_CLRBITS;
                     default: dec_ok = 1'b0;
                  endcase
               end
            end
            rv32im_dec_pkg::OPC_TRAP: begin
               s2_dec_in.fmt = rv32im_dec_pkg::FMT_U;
               s2_dec_in.op  = rv32im_dec_pkg::OP_TRAP;
            end
            default: dec_ok = 1'b0;
         endcase
         if (!dec_ok) begin
            s2_dec_in.kind = rv32im_dec_pkg::KIND_ILLEGAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_word_ff <= s1_word_ff;
         s2_dec_ff  <= s2_dec_in;
      end
   end

   // ---- stage 3: register fields and immediate ----
   always_comb begin
      op_in   = s2_dec_ff.op;
      fmt_in  = s2_dec_ff.fmt;
      csr_in  = s2_dec_ff.csr;
      src1_in = 5'd0;
      src2_in = 5'd0;
      dest_in = 5'd0;
      imm_in  = 32'd0;
      comp_in = 1'b0;
      ill_in  = 1'b0;
      case (s2_dec_ff.kind)
         rv32im_dec_pkg::KIND_CJAL: begin
            dest_in = rv32im_dec_pkg::REG_RA;
            comp_in = 1'b1;
            imm_in  = {{20{s2_word_ff[12]}}, s2_word_ff[12], s2_word_ff[8],
                       s2_word_ff[10:9], s2_word_ff[6], s2_word_ff[7],
                       s2_word_ff[2], s2_word_ff[11], s2_word_ff[5:3], 1'b0};
         end
         rv32im_dec_pkg::KIND_SYSWORD: begin
            // exact ECALL/MRET/FENCE: op and format only
         end
         rv32im_dec_pkg::KIND_ILLEGAL: begin
            op_in  = rv32im_dec_pkg::OP_ADD;
            fmt_in = rv32im_dec_pkg::FMT_R;
            csr_in = rv32im_dec_pkg::CSR_NONE;
            ill_in = 1'b1;
         end
         default: begin
            case (s2_dec_ff.fmt)
               rv32im_dec_pkg::FMT_R: begin
                  src1_in = s2_word_ff[19:15];
                  src2_in = s2_word_ff[24:20];
                  dest_in = s2_word_ff[11:7];
               end
               rv32im_dec_pkg::FMT_I: begin
                  src1_in = s2_word_ff[19:15];
                  dest_in = s2_word_ff[11:7];
                  imm_in  = {{20{s2_word_ff[31]}}, s2_word_ff[31:20]};
               end
               rv32im_dec_pkg::FMT_S: begin
                  src1_in = s2_word_ff[19:15];
                  src2_in = s2_word_ff[24:20];
                  imm_in  = {{20{s2_word_ff[31]}}, s2_word_ff[31:25],
                             s2_word_ff[11:7]};
               end
               rv32im_dec_pkg::FMT_B: begin
                  src1_in = s2_word_ff[19:15];
                  src2_in = s2_word_ff[24:20];
                  imm_in  = {{19{s2_word_ff[31]}}, s2_word_ff[31], s2_word_ff[7],
                             s2_word_ff[30:25], s2_word_ff[11:8], 1'b0};
               end
               rv32im_dec_pkg::FMT_U: begin
                  dest_in = s2_word_ff[11:7];
                  imm_in  = {s2_word_ff[31:12], 12'd0};
               end
               default: begin
                  dest_in = s2_word_ff[11:7];
                  imm_in  = {{11{s2_word_ff[31]}}, s2_word_ff[31],
                             s2_word_ff[19:12], s2_word_ff[20],
                             s2_word_ff[30:21], 1'b0};
               end
            endcase
         end
      endcase
      we_in = (dest_in != 5'd0);
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         op_ff   <= op_in;
         fmt_ff  <= fmt_in;
         src1_ff <= src1_in;
         src2_ff <= src2_in;
         dest_ff <= dest_in;
         we_ff   <= we_in;
         imm_ff  <= imm_in;
         csr_ff  <= csr_in;
         comp_ff <= comp_in;
         ill_ff  <= ill_in;
      end
   end

   assign rsp_valid         = s3_valid_ff;
   assign rsp_op_index      = op_ff;
   assign rsp_format_kind   = fmt_ff;
   assign rsp_src1_reg      = src1_ff;
   assign rsp_src2_reg      = src2_ff;
   assign rsp_dest_reg      = dest_ff;
   assign rsp_dest_write    = we_ff;
   assign rsp_immediate     = $signed(imm_ff);
   assign rsp_csr_index     = csr_ff;
   assign rsp_is_compressed = comp_ff;
   assign rsp_illegal       = ill_ff;

`ifndef SYNTHESIS
   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal |->
         rsp_op_index == rv32im_dec_pkg::OP_ADD &&
         rsp_csr_index == rv32im_dec_pkg::CSR_NONE && !rsp_dest_write)
      else $error("illegal result carries decode fields");

   a_write_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_write |-> rsp_dest_reg != 5'd0)
      else $error("write enable with rd zero");

   a_cjal_links_ra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_compressed |->
         rsp_op_index == rv32im_dec_pkg::OP_CJAL &&
         rsp_dest_reg == rv32im_dec_pkg::REG_RA && !rsp_illegal)
      else $error("compressed jump decoded wrongly");

   a_csr_only_csr_ops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_csr_index != rv32im_dec_pkg::CSR_NONE |->
         rsp_op_index == rv32im_dec_pkg::OP_CSR_SWAP ||
         rsp_op_index == rv32im_dec_pkg::OP_CSR_SETBITS ||
         rsp_op_index == rv32im_dec_pkg::OP_CSR_CLRBITS)
      else $error("CSR index on a non-CSR op");

   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_adv |=> s2_valid_ff && $stable(s2_word_ff))
      else $error("classify stage lost a held item");
`endif

endmodule
